// ===== sv/htst_pkg.sv =====
package htst_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Field widths
  localparam int ADDR_W  = 48;
  localparam int LT_W    = 2;
  localparam int LEN_W   = 16;
  localparam int SEC_W   = 16;
  localparam int CTR_W   = 64;
  localparam int SPAN_W  = 48;
  localparam int RATE_W  = 32;
  localparam int KIND_W  = 3;
  localparam int EIDX_W  = 6;
  localparam int KEY_W   = ADDR_W + LT_W;

  // Serial divider: quotient of up to (span << 4), divisor up to 16 bits
  localparam int DIV_W     = SPAN_W + 4;
  localparam int DVSR_W    = SEC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // span*8/1000 reduces to span/125; span/1024 is a shift by 10
  localparam int KBIT_DIV   = 125;
  localparam int KBYTE_SHFT = 10;

  // Divide by 125 by folding against 128: 128*t + u leaves u + 3*t
  localparam int KBIT_SHFT  = 7;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SRC_BASE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DST_BASE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REPORT   = 3'd6;

  // Lookup outcome, added to the kind base
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_ADDED   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  // Per-entry counter record
  typedef struct packed {
    logic [CTR_W-1:0]  in_pk;
    logic [CTR_W-1:0]  in_ip;
    logic [CTR_W-1:0]  in_by;
    logic [CTR_W-1:0]  out_pk;
    logic [CTR_W-1:0]  out_ip;
    logic [CTR_W-1:0]  out_by;
    logic [SPAN_W-1:0] span_in;
    logic [SPAN_W-1:0] span_out;
  } cnt_entry_t;

  localparam int ENTRY_W = $bits(cnt_entry_t);

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SCAN_NEXT,
    OP_HIT,
    OP_MISS,
    OP_UPDATE,
    OP_NEXT_SIDE,
    OP_TICK_LOAD,
    OP_Q_SHIFT,
    OP_Q_DIV,
    OP_Q_TAKE,
    OP_R_DIV,
    OP_R_TAKE,
    OP_NEXT_ENTRY
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic idx_lt_cnt;
    logic cnt_zero;
    logic side;
    logic dir;
    logic div_busy;
    logic rate_unit;
    logic last_entry;
    logic is_tick;
  } dp_stat_t;

endpackage

// ===== sv/htst_if.sv =====
interface htst_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [htst_pkg::ADDR_W-1:0]   source_addr;
  logic [htst_pkg::ADDR_W-1:0]   dest_addr;
  logic [htst_pkg::LT_W-1:0]     link_type;
  logic [htst_pkg::LEN_W-1:0]    packet_length;
  logic                          is_ip;
  logic [htst_pkg::SEC_W-1:0]    elapsed_seconds;

  modport source (output valid, opcode, source_addr, dest_addr, link_type,
                  packet_length, is_ip, elapsed_seconds, input ready);
  modport sink (input valid, opcode, source_addr, dest_addr, link_type,
                packet_length, is_ip, elapsed_seconds, output ready);
endinterface

interface htst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [htst_pkg::KIND_W-1:0]   kind;
  logic [htst_pkg::EIDX_W-1:0]   entry_index;
  logic [htst_pkg::ADDR_W-1:0]   host_addr;
  logic [htst_pkg::CTR_W-1:0]    in_packets;
  logic [htst_pkg::CTR_W-1:0]    in_ip_packets;
  logic [htst_pkg::CTR_W-1:0]    in_bytes;
  logic [htst_pkg::CTR_W-1:0]    out_packets;
  logic [htst_pkg::CTR_W-1:0]    out_ip_packets;
  logic [htst_pkg::CTR_W-1:0]    out_bytes;
  logic [htst_pkg::RATE_W-1:0]   in_rate;
  logic [htst_pkg::RATE_W-1:0]   out_rate;
  logic                          last;

  modport source (output valid, kind, entry_index, host_addr, in_packets,
                  in_ip_packets, in_bytes, out_packets, out_ip_packets, out_bytes,
                  in_rate, out_rate, last, input ready);
  modport sink (input valid, kind, entry_index, host_addr, in_packets,
                in_ip_packets, in_bytes, out_packets, out_ip_packets, out_bytes,
                in_rate, out_rate, last, output ready);
endinterface

interface htst_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/htst_ram.sv =====
module htst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/htst_div.sv =====
module htst_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [htst_pkg::DIV_W-1:0]  dividend,
  input  logic [htst_pkg::DVSR_W-1:0] divisor,
  output logic                        busy,
  output logic [htst_pkg::DIV_W-1:0]  quotient
);

  logic [htst_pkg::DIV_CNT_W-1:0] cnt;
  logic [htst_pkg::DVSR_W-1:0]    rem;
  logic [htst_pkg::DVSR_W-1:0]    dvsr;
  logic [htst_pkg::DVSR_W:0]      rem_sh;
  logic                           fits;

  // One restoring step: bring down the next dividend bit
  assign rem_sh = {rem, quotient[htst_pkg::DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvsr};

  // Step count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= htst_pkg::DIV_CNT_W'(htst_pkg::DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == htst_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift quotient in, keep partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvsr     <= divisor;
    end else if (busy) begin
      quotient <= {quotient[htst_pkg::DIV_W-2:0], fits};
      if (fits) begin
        rem <= htst_pkg::DVSR_W'(rem_sh - {1'b0, dvsr});
      end else begin
        rem <= rem_sh[htst_pkg::DVSR_W-1:0];
      end
    end
  end

endmodule

// ===== sv/htst_dp.sv =====
module htst_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  htst_pkg::dp_cmd_t            cmd,
  output htst_pkg::dp_stat_t           stat,
  input  logic                         cfg_we,
  input  logic                         cfg_data,
  input  logic                         opcode,
  input  logic [htst_pkg::ADDR_W-1:0]  source_addr,
  input  logic [htst_pkg::ADDR_W-1:0]  dest_addr,
  input  logic [htst_pkg::LT_W-1:0]    link_type,
  input  logic [htst_pkg::LEN_W-1:0]   packet_length,
  input  logic                         is_ip,
  input  logic [htst_pkg::SEC_W-1:0]   elapsed_seconds,
  output logic [htst_pkg::KIND_W-1:0]  kind,
  output logic [htst_pkg::EIDX_W-1:0]  entry_index,
  output logic [htst_pkg::ADDR_W-1:0]  host_addr,
  output logic [htst_pkg::CTR_W-1:0]   in_packets,
  output logic [htst_pkg::CTR_W-1:0]   in_ip_packets,
  output logic [htst_pkg::CTR_W-1:0]   in_bytes,
  output logic [htst_pkg::CTR_W-1:0]   out_packets,
  output logic [htst_pkg::CTR_W-1:0]   out_ip_packets,
  output logic [htst_pkg::CTR_W-1:0]   out_bytes,
  output logic [htst_pkg::RATE_W-1:0]  in_rate,
  output logic [htst_pkg::RATE_W-1:0]  out_rate,
  output logic                         last
);

  // Control registers
  logic                        rate_unit;
  logic [htst_pkg::CNT_W-1:0]  count;
  logic [htst_pkg::CNT_W-1:0]  idx;
  logic [htst_pkg::IDX_W-1:0]  pos;
  logic [1:0]                  st;
  logic                        side;
  logic                        dir;
  logic                        is_tick;

  // Request payload
  logic [htst_pkg::ADDR_W-1:0] src_r;
  logic [htst_pkg::ADDR_W-1:0] dst_r;
  logic [htst_pkg::LT_W-1:0]   lt_r;
  logic [htst_pkg::LEN_W-1:0]  len_r;
  logic                        ip_r;
  logic [htst_pkg::SEC_W-1:0]  sec_r;

  // Rate work registers
  logic [htst_pkg::SPAN_W-1:0] span_in_r;
  logic [htst_pkg::SPAN_W-1:0] span_out_r;
  logic [htst_pkg::SPAN_W-1:0] q_r;
  logic [htst_pkg::SPAN_W-1:0] kq_acc;
  logic [htst_pkg::SPAN_W-1:0] kq_rem;
  logic                        kq_busy;

  // Memory ports
  logic                        key_we;
  logic [htst_pkg::KEY_W-1:0]  key_rdata;
  logic                        cnt_we;
  logic [htst_pkg::IDX_W-1:0]  cnt_addr;
  htst_pkg::cnt_entry_t        cnt_rdata;
  htst_pkg::cnt_entry_t        cnt_wdata;

  // Combinational
  logic                        full;
  logic [htst_pkg::ADDR_W-1:0] cur_addr;
  htst_pkg::cnt_entry_t        base;
  htst_pkg::cnt_entry_t        upd;
  htst_pkg::cnt_entry_t        cleared;
  logic [htst_pkg::SPAN_W-1:0] span_sel;
  logic [htst_pkg::SPAN_W-1:0] kq_hi;
  logic                        kq_done;
  logic                        div_start;
  logic                        div_busy;
  logic [htst_pkg::DIV_W-1:0]  div_dividend;
  logic [htst_pkg::DVSR_W-1:0] div_divisor;
  logic [htst_pkg::DIV_W-1:0]  div_quo;
  logic [htst_pkg::RATE_W-1:0] quo_sat;

  assign full     = count == htst_pkg::CNT_W'(htst_pkg::TABLE_DEPTH);
  assign cur_addr = side ? dst_r : src_r;
  assign span_sel = dir ? span_out_r : span_in_r;

  // Status to the controller
  assign stat.hit        = key_rdata == {lt_r, cur_addr};
  assign stat.idx_lt_cnt = idx < count;
  assign stat.cnt_zero   = count == '0;
  assign stat.side       = side;
  assign stat.dir        = dir;
  assign stat.div_busy   = div_busy | kq_busy;
  assign stat.rate_unit  = rate_unit;
  assign stat.last_entry = (idx + 1'b1) == count;
  assign stat.is_tick    = is_tick;

  // Apply one packet to the entry: source gets out counters, dest in counters
  always_comb begin
    base = (st == htst_pkg::ST_ADDED) ? '0 : cnt_rdata;
    upd  = base;
    if (side) begin
      upd.in_pk   = base.in_pk + 1'b1;
      upd.in_ip   = base.in_ip + htst_pkg::CTR_W'(ip_r);
      upd.in_by   = base.in_by + htst_pkg::CTR_W'(len_r);
      upd.span_in = base.span_in + htst_pkg::SPAN_W'(len_r);
    end else begin
      upd.out_pk   = base.out_pk + 1'b1;
      upd.out_ip   = base.out_ip + htst_pkg::CTR_W'(ip_r);
      upd.out_by   = base.out_by + htst_pkg::CTR_W'(len_r);
      upd.span_out = base.span_out + htst_pkg::SPAN_W'(len_r);
    end
    cleared          = cnt_rdata;
    cleared.span_in  = '0;
    cleared.span_out = '0;
  end

  // Memory control
  assign key_we    = (cmd.op == htst_pkg::OP_MISS) && !full;
  assign cnt_we    = ((cmd.op == htst_pkg::OP_UPDATE) && (st != htst_pkg::ST_DROPPED))
                     || (cmd.op == htst_pkg::OP_TICK_LOAD);
  assign cnt_addr  = is_tick ? idx[htst_pkg::IDX_W-1:0] : pos;
  assign cnt_wdata = is_tick ? cleared : upd;

  htst_ram #(
    .WIDTH (htst_pkg::KEY_W),
    .DEPTH (htst_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (count[htst_pkg::IDX_W-1:0]),
    .wdata ({lt_r, cur_addr}),
    .raddr (idx[htst_pkg::IDX_W-1:0]),
    .rdata (key_rdata)
  );

  htst_ram #(
    .WIDTH (htst_pkg::ENTRY_W),
    .DEPTH (htst_pkg::TABLE_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_addr),
    .wdata (cnt_wdata),
    .raddr (cnt_addr),
    .rdata (cnt_rdata)
  );

  // Divide span by 125: fold the part above 128 down until under 128
  assign kq_hi   = kq_rem >> htst_pkg::KBIT_SHFT;
  assign kq_done = kq_hi == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kq_busy <= 1'b0;
    end else if (cmd.op == htst_pkg::OP_Q_DIV) begin
      kq_busy <= 1'b1;
    end else if (kq_busy && kq_done) begin
      kq_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == htst_pkg::OP_Q_DIV) begin
      kq_acc <= '0;
      kq_rem <= span_sel;
    end else if (kq_busy) begin
      if (kq_done) begin
        if (kq_rem >= htst_pkg::SPAN_W'(htst_pkg::KBIT_DIV)) begin
          kq_acc <= kq_acc + 1'b1;
        end
      end else begin
        kq_acc <= kq_acc + kq_hi;
        kq_rem <= {{(htst_pkg::SPAN_W-htst_pkg::KBIT_SHFT){1'b0}},
                   kq_rem[htst_pkg::KBIT_SHFT-1:0]} + (kq_hi << 1) + kq_hi;
      end
    end
  end

  // Divider operands: (q*16)/seconds
  assign div_start    = cmd.op == htst_pkg::OP_R_DIV;
  assign div_dividend = {q_r, 4'b0000};
  assign div_divisor  = sec_r;
  assign quo_sat      = (|div_quo[htst_pkg::DIV_W-1:htst_pkg::RATE_W]) ? '1
                                                       : div_quo[htst_pkg::RATE_W-1:0];

  htst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_unit <= 1'b0;
      count     <= '0;
      idx       <= '0;
      pos       <= '0;
      st        <= htst_pkg::ST_FOUND;
      side      <= 1'b0;
      dir       <= 1'b0;
      is_tick   <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_unit <= cfg_data;
      end
      unique case (cmd.op)
        htst_pkg::OP_CAPTURE: begin
          idx     <= '0;
          side    <= 1'b0;
          dir     <= 1'b0;
          is_tick <= opcode;
        end
        htst_pkg::OP_SCAN_NEXT, htst_pkg::OP_NEXT_ENTRY: begin
          idx <= idx + 1'b1;
        end
        htst_pkg::OP_HIT: begin
          pos <= idx[htst_pkg::IDX_W-1:0];
          st  <= htst_pkg::ST_FOUND;
        end
        htst_pkg::OP_MISS: begin
          if (full) begin
            pos <= '0;
            st  <= htst_pkg::ST_DROPPED;
          end else begin
            pos   <= count[htst_pkg::IDX_W-1:0];
            st    <= htst_pkg::ST_ADDED;
            count <= count + 1'b1;
          end
        end
        htst_pkg::OP_NEXT_SIDE: begin
          side <= 1'b1;
          idx  <= '0;
        end
        htst_pkg::OP_TICK_LOAD: begin
          dir <= 1'b0;
        end
        htst_pkg::OP_R_TAKE: begin
          dir <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload and result registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      htst_pkg::OP_CAPTURE: begin
        src_r <= source_addr;
        dst_r <= dest_addr;
        lt_r  <= link_type;
        len_r <= packet_length;
        ip_r  <= is_ip;
        sec_r <= (elapsed_seconds == '0) ? htst_pkg::SEC_W'(1) : elapsed_seconds;
      end
      htst_pkg::OP_UPDATE: begin
        kind      <= (side ? htst_pkg::KIND_DST_BASE : htst_pkg::KIND_SRC_BASE)
                     + htst_pkg::KIND_W'(st);
        entry_index <= htst_pkg::EIDX_W'(pos);
        host_addr <= cur_addr;
        in_rate   <= '0;
        out_rate  <= '0;
        last      <= side;
        if (st == htst_pkg::ST_DROPPED) begin
          in_packets     <= '0;
          in_ip_packets  <= '0;
          in_bytes       <= '0;
          out_packets    <= '0;
          out_ip_packets <= '0;
          out_bytes      <= '0;
        end else begin
          in_packets     <= upd.in_pk;
          in_ip_packets  <= upd.in_ip;
          in_bytes       <= upd.in_by;
          out_packets    <= upd.out_pk;
          out_ip_packets <= upd.out_ip;
          out_bytes      <= upd.out_by;
        end
      end
      htst_pkg::OP_TICK_LOAD: begin
        kind           <= htst_pkg::KIND_REPORT;
        entry_index    <= htst_pkg::EIDX_W'(idx);
        host_addr      <= key_rdata[htst_pkg::ADDR_W-1:0];
        in_packets     <= cnt_rdata.in_pk;
        in_ip_packets  <= cnt_rdata.in_ip;
        in_bytes       <= cnt_rdata.in_by;
        out_packets    <= cnt_rdata.out_pk;
        out_ip_packets <= cnt_rdata.out_ip;
        out_bytes      <= cnt_rdata.out_by;
        last           <= stat.last_entry;
        span_in_r      <= cnt_rdata.span_in;
        span_out_r     <= cnt_rdata.span_out;
      end
      htst_pkg::OP_Q_SHIFT: begin
        q_r <= span_sel >> htst_pkg::KBYTE_SHFT;
      end
      htst_pkg::OP_Q_TAKE: begin
        q_r <= kq_acc;
      end
      htst_pkg::OP_R_TAKE: begin
        if (dir) begin
          out_rate <= quo_sat;
        end else begin
          in_rate <= quo_sat;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/htst_ctrl.sv =====
module htst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_opcode,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  htst_pkg::dp_stat_t stat,
  output htst_pkg::dp_cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_SCAN_RD  = 13'b0000000000010,
    S_SCAN_CMP = 13'b0000000000100,
    S_MISS     = 13'b0000000001000,
    S_CNT_RD   = 13'b0000000010000,
    S_UPD      = 13'b0000000100000,
    S_EMIT     = 13'b0000001000000,
    S_T_RD     = 13'b0000010000000,
    S_T_LOAD   = 13'b0000100000000,
    S_Q        = 13'b0001000000000,
    S_Q_WAIT   = 13'b0010000000000,
    S_R        = 13'b0100000000000,
    S_R_WAIT   = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the lookups, counter update and rate divisions
  always_comb begin
    state_next = state;
    cmd.op     = htst_pkg::OP_NONE;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op = htst_pkg::OP_CAPTURE;
          if (!req_opcode) begin
            state_next = S_SCAN_RD;
          end else if (!stat.cnt_zero) begin
            state_next = S_T_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_next = stat.idx_lt_cnt ? S_SCAN_CMP : S_MISS;
      end
      S_SCAN_CMP: begin
        if (stat.hit) begin
          cmd.op     = htst_pkg::OP_HIT;
          state_next = S_CNT_RD;
        end else begin
          cmd.op     = htst_pkg::OP_SCAN_NEXT;
          state_next = S_SCAN_RD;
        end
      end
      S_MISS: begin
        cmd.op     = htst_pkg::OP_MISS;
        state_next = S_CNT_RD;
      end
      S_CNT_RD: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op     = htst_pkg::OP_UPDATE;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          if (stat.is_tick) begin
            if (stat.last_entry) begin
              state_next = S_IDLE;
            end else begin
              cmd.op     = htst_pkg::OP_NEXT_ENTRY;
              state_next = S_T_RD;
            end
          end else if (stat.side) begin
            state_next = S_IDLE;
          end else begin
            cmd.op     = htst_pkg::OP_NEXT_SIDE;
            state_next = S_SCAN_RD;
          end
        end
      end
      S_T_RD: begin
        state_next = S_T_LOAD;
      end
      S_T_LOAD: begin
        cmd.op     = htst_pkg::OP_TICK_LOAD;
        state_next = S_Q;
      end
      S_Q: begin
        if (stat.rate_unit) begin
          cmd.op     = htst_pkg::OP_Q_SHIFT;
          state_next = S_R;
        end else begin
          cmd.op     = htst_pkg::OP_Q_DIV;
          state_next = S_Q_WAIT;
        end
      end
      S_Q_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = htst_pkg::OP_Q_TAKE;
          state_next = S_R;
        end
      end
      S_R: begin
        cmd.op     = htst_pkg::OP_R_DIV;
        state_next = S_R_WAIT;
      end
      S_R_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = htst_pkg::OP_R_TAKE;
          state_next = stat.dir ? S_EMIT : S_Q;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/host_traffic_stats_table_unit.sv =====
// Packet request: each lookup searches the table one entry at a time, reading and
// then comparing each stored key; a packet gives two results, source then dest.
// Tick request: per entry, kilobit mode runs two 52-step serial divisions by the
// seconds plus two divide-by-125 folds; kilobyte mode takes a shift by 10 in place
// of each fold. One request is in flight at a time. Reset clears the entry count
// and selects kilobit rates.
module host_traffic_stats_table_unit (
  input  logic       clk,
  input  logic       rst,
  htst_req_if.sink   req,
  htst_rsp_if.source rsp,
  htst_cfg_if.sink   cfg
);

  htst_pkg::dp_cmd_t  cmd;
  htst_pkg::dp_stat_t stat;
  logic               req_ready;
  logic               rsp_valid;

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign cfg.ready = 1'b1;

  htst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req_ready),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  htst_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.data),
    .opcode          (req.opcode),
    .source_addr     (req.source_addr),
    .dest_addr       (req.dest_addr),
    .link_type       (req.link_type),
    .packet_length   (req.packet_length),
    .is_ip           (req.is_ip),
    .elapsed_seconds (req.elapsed_seconds),
    .kind            (rsp.kind),
    .entry_index     (rsp.entry_index),
    .host_addr       (rsp.host_addr),
    .in_packets      (rsp.in_packets),
    .in_ip_packets   (rsp.in_ip_packets),
    .in_bytes        (rsp.in_bytes),
    .out_packets     (rsp.out_packets),
    .out_ip_packets  (rsp.out_ip_packets),
    .out_bytes       (rsp.out_bytes),
    .in_rate         (rsp.in_rate),
    .out_rate        (rsp.out_rate),
    .last            (rsp.last)
  );

endmodule
